@@ rtl/pmdi_pkg.sv @@
`timescale 1ns / 1ps

package pmdi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int QUOT_W    = PROD_W - FRAC_BITS;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W     = 32;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam longint WMAX_L = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint WMIN_L = -WMAX_L - 1;
  localparam word_t  WMAX   = WORD_BITS'(WMAX_L);
  localparam word_t  WMIN   = WORD_BITS'(WMIN_L);

  // Rounded fixed-point constants: 0.15 snap threshold, 0.3 twist gain, 5.0 drive drag.
  localparam longint SNAP_L    = ((longint'(15) << FRAC_BITS) + 50) / 100;
  localparam longint K03_L     = ((longint'(3) << FRAC_BITS) + 5) / 10;
  localparam longint DRIVE_L   = longint'(5) << FRAC_BITS;
  localparam word_t  SNAP      = WORD_BITS'(SNAP_L);
  localparam word_t  K03       = WORD_BITS'(K03_L);
  localparam word_t  K03_NEG   = WORD_BITS'(-K03_L);
  localparam word_t  DRIVE_DRAG = WORD_BITS'((DRIVE_L > WMAX_L) ? WMAX_L : DRIVE_L);

  typedef enum logic [2:0] {
    REG_THRUST  = 3'd0,
    REG_INV_MASS = 3'd1,
    REG_TIME_STEP = 3'd2,
    REG_RESIST_X = 3'd3,
    REG_RESIST_Y = 3'd4,
    REG_RESIST_Z = 3'd5,
    REG_IDLE_DRAG = 3'd6
  } cfg_reg_t;

  // Register values as the datapath sees them, already saturated to a word.
  typedef struct packed {
    word_t thrust;
    word_t inv_mass;
    word_t time_step;
    word_t resist_x;
    word_t resist_y;
    word_t resist_z;
    word_t drag_now;
  } pmdi_cfg_t;

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WMIN : WMAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_u32(input logic [31:0] x);
    longint e;
    e = longint'({32'd0, x});
    if (e > WMAX_L) begin
      return WMAX;
    end
    return WORD_BITS'(e);
  endfunction

  function automatic word_t sat_s32(input logic signed [31:0] x);
    longint e;
    e = longint'(x);
    if (e > WMAX_L) begin
      return WMAX;
    end
    if (e < WMIN_L) begin
      return WMIN;
    end
    return WORD_BITS'(e);
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input word_t w);
    longint e;
    e = longint'(w);
    return e[OUT_W-1:0];
  endfunction

endpackage

@@ rtl/pmdi_fmul.sv @@
`timescale 1ns / 1ps

// Saturating fixed-point multiplier with two register stages.
module pmdi_fmul import pmdi_pkg::*; (
  input  logic  clk,
  input  word_t op_a,
  input  word_t op_b,
  output word_t result
);

  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;
  logic [PROD_W-1:0]    prod_r;
  logic                 neg_r;
  logic [QUOT_W-1:0]    quot;
  logic [QUOT_W-1:0]    lim;
  word_t                res_nxt;
  word_t                res_r;

  assign mag_a = op_a[WORD_BITS-1] ? WORD_BITS'(-op_a) : op_a;
  assign mag_b = op_b[WORD_BITS-1] ? WORD_BITS'(-op_b) : op_b;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mag_a) * PROD_W'(mag_b);
    neg_r  <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
  end

  // Truncate toward zero on the magnitude, then apply sign and saturate.
  always_comb begin
    quot = prod_r[PROD_W-1:FRAC_BITS];
    lim  = neg_r ? QUOT_W'(WMAX_L) + QUOT_W'(1) : QUOT_W'(WMAX_L);
    if (quot > lim) begin
      res_nxt = neg_r ? WMIN : WMAX;
    end else if (neg_r) begin
      res_nxt = WORD_BITS'(-quot);
    end else begin
      res_nxt = WORD_BITS'(quot);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

@@ rtl/pmdi_cfg.sv @@
`timescale 1ns / 1ps

// Configuration registers and the drag coefficient that drive latches.
module pmdi_cfg import pmdi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  drive_set,
  output pmdi_cfg_t             cfg
);

  logic [30:0] thrust_r;
  logic [30:0] inv_mass_r;
  logic [16:0] time_step_r;
  logic signed [31:0] resist_x_r;
  logic signed [31:0] resist_y_r;
  logic signed [31:0] resist_z_r;
  word_t       drag_r;
  logic        driven_r;

  // The idle drag value only matters at the moment it is written, so it is
  // loaded straight into the live coefficient and not kept on its own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_r    <= 31'd65536;
      inv_mass_r  <= 31'd65536;
      time_step_r <= 17'd1092;
      resist_x_r  <= '0;
      resist_y_r  <= '0;
      resist_z_r  <= '0;
      drag_r      <= sat_u32(32'd327680);
      driven_r    <= 1'b0;
    end else begin
      if (drive_set) begin
        drag_r   <= DRIVE_DRAG;
        driven_r <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_THRUST:    thrust_r    <= cfg_data[30:0];
          REG_INV_MASS:  inv_mass_r  <= cfg_data[30:0];
          REG_TIME_STEP: time_step_r <= cfg_data[16:0];
          REG_RESIST_X:  resist_x_r  <= cfg_data[31:0];
          REG_RESIST_Y:  resist_y_r  <= cfg_data[31:0];
          REG_RESIST_Z:  resist_z_r  <= cfg_data[31:0];
          REG_IDLE_DRAG: begin
            if (!driven_r && !drive_set) begin
              drag_r <= sat_u32({9'd0, cfg_data[22:0]});
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.thrust    = sat_u32({1'b0, thrust_r});
    cfg.inv_mass  = sat_u32({1'b0, inv_mass_r});
    cfg.time_step = sat_u32({15'd0, time_step_r});
    cfg.resist_x  = sat_s32(resist_x_r);
    cfg.resist_y  = sat_s32(resist_y_r);
    cfg.resist_z  = sat_s32(resist_z_r);
    cfg.drag_now  = drag_r;
  end

endmodule

@@ rtl/point_mass_drag_integrator_top.sv @@
`timescale 1ns / 1ps

// One explicit Euler tick of a point mass with signed quadratic drag, in Q16.16
// fixed point with saturation on every product and sum. Each input transfer
// carries a motor direction per axis; the block updates velocity and position
// of all three axes and returns one result transfer with the new velocity,
// the new position and the two twist terms. All arithmetic runs through one
// shared two-stage multiplier and one saturating adder under a small
// sequencer: an item makes seventeen products, each followed by the S_WAIT
// state for the multiplier, and its result is then loaded into the output
// register. The next input transfer can come only after that load, so one
// item is finished before the next one is taken.
// The input is not ready while an item is in work. The output register lets a
// new item start while the previous result still waits to be taken; a finished
// item then holds until that register is free. Configuration writes through the
// cfg_ port take effect at once and are meant for times when no item is in work.
module point_mass_drag_integrator_top import pmdi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [1:0]     in_push_x,
  input  logic signed [1:0]     in_push_y,
  input  logic signed [1:0]     in_push_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [OUT_W-1:0] out_velocity_x,
  output logic signed [OUT_W-1:0] out_velocity_y,
  output logic signed [OUT_W-1:0] out_velocity_z,
  output logic signed [OUT_W-1:0] out_position_x,
  output logic signed [OUT_W-1:0] out_position_y,
  output logic signed [OUT_W-1:0] out_position_z,
  output logic signed [OUT_W-1:0] out_twist_x,
  output logic signed [OUT_W-1:0] out_twist_z,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The sequencer walks the per-axis recipe: v*v, drag*v^2, force sum,
  // force*inverse mass, acceleration*dt, velocity update, velocity*dt and
  // position update. Every multiply state is followed by S_WAIT, which returns
  // to the state held in ret_r once the product is in the multiplier's output.
  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_VV   = 15'h0002,
    S_DRG  = 15'h0004,
    S_F1   = 15'h0008,
    S_F2   = 15'h0010,
    S_ACC  = 15'h0020,
    S_DV   = 15'h0040,
    S_UV   = 15'h0080,
    S_DP   = 15'h0100,
    S_UP   = 15'h0200,
    S_TWX  = 15'h0400,
    S_TWZ  = 15'h0800,
    S_TWC  = 15'h1000,
    S_DONE = 15'h2000,
    S_WAIT = 15'h4000
  } state_t;

  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;
  logic [1:0]  ax_r;
  logic [1:0]  push_r [3];
  word_t       speed_r [3];
  word_t       place_r [3];
  word_t       tmp_r;
  word_t       twx_r;
  word_t       twz_r;
  logic        out_valid_r;
  logic [OUT_W-1:0] out_vel_r [3];
  logic [OUT_W-1:0] out_pos_r [3];
  logic [OUT_W-1:0] out_twx_r;
  logic [OUT_W-1:0] out_twz_r;

  pmdi_cfg_t   cfg;
  logic        in_take;
  logic        idle_push;
  logic        out_load;
  word_t       mul_a, mul_b, mres;
  word_t       v_cur, p_cur, resist_cur, motor, drag_term;
  logic [1:0]  dir_cur;

  assign in_ready  = (state_r == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign idle_push = (in_push_x == 2'sd0) && (in_push_y == 2'sd0) && (in_push_z == 2'sd0);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  pmdi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .drive_set (in_take && !idle_push),
    .cfg       (cfg)
  );

  pmdi_fmul u_fmul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .result (mres)
  );

  // Operands and constants of the axis in work.
  always_comb begin
    v_cur   = speed_r[ax_r];
    p_cur   = place_r[ax_r];
    dir_cur = push_r[ax_r];
    case (ax_r)
      2'd0:    resist_cur = cfg.resist_x;
      2'd1:    resist_cur = cfg.resist_y;
      default: resist_cur = cfg.resist_z;
    endcase
    // A set sign bit counts as backward, whatever the low bit says.
    if (dir_cur[1]) begin
      motor = WORD_BITS'(-cfg.thrust);
    end else if (dir_cur[0]) begin
      motor = cfg.thrust;
    end else begin
      motor = '0;
    end
    // The drag product is never negative, so its negation cannot overflow.
    drag_term = (v_cur > 0) ? WORD_BITS'(-mres) : mres;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_VV: begin
        mul_a = v_cur;
        mul_b = v_cur;
      end
      S_DRG: begin
        mul_a = cfg.drag_now;
        mul_b = mres;
      end
      S_ACC: begin
        mul_a = tmp_r;
        mul_b = cfg.inv_mass;
      end
      S_DV: begin
        mul_a = mres;
        mul_b = cfg.time_step;
      end
      S_DP: begin
        mul_a = v_cur;
        mul_b = cfg.time_step;
      end
      S_TWX: begin
        mul_a = K03_NEG;
        mul_b = speed_r[0];
      end
      S_TWZ: begin
        mul_a = K03;
        mul_b = speed_r[2];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      S_IDLE: if (in_take) state_nxt = S_VV;
      S_VV: begin
        state_nxt = S_WAIT;
        ret_nxt   = S_DRG;
      end
      S_DRG: begin
        state_nxt = S_WAIT;
        ret_nxt   = S_F1;
      end
      S_F1:  state_nxt = S_F2;
      S_F2:  state_nxt = S_ACC;
      S_ACC: begin
        state_nxt = S_WAIT;
        ret_nxt   = S_DV;
      end
      S_DV: begin
        state_nxt = S_WAIT;
        ret_nxt   = S_UV;
      end
      S_UV:  state_nxt = S_DP;
      S_DP: begin
        state_nxt = S_WAIT;
        ret_nxt   = S_UP;
      end
      S_UP:  state_nxt = (ax_r == 2'd2) ? S_TWX : S_VV;
      S_TWX: begin
        state_nxt = S_WAIT;
        ret_nxt   = S_TWZ;
      end
      S_TWZ: begin
        state_nxt = S_WAIT;
        ret_nxt   = S_TWC;
      end
      S_TWC:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      S_WAIT: state_nxt = ret_r;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      ax_r        <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        speed_r[i] <= '0;
        place_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;

      if (in_take) begin
        ax_r <= 2'd0;
        // With no axis driven, slow components come to rest before the tick.
        if (idle_push) begin
          for (int i = 0; i < 3; i++) begin
            if ((speed_r[i] < SNAP) && (speed_r[i] > -SNAP)) begin
              speed_r[i] <= '0;
            end
          end
        end
      end

      if (state_r == S_UV) begin
        speed_r[ax_r] <= sat_add(v_cur, mres);
      end
      if (state_r == S_UP) begin
        place_r[ax_r] <= sat_add(p_cur, mres);
        if (ax_r != 2'd2) begin
          ax_r <= ax_r + 2'd1;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      push_r[0] <= in_push_x;
      push_r[1] <= in_push_y;
      push_r[2] <= in_push_z;
    end
    case (state_r)
      S_F1:  tmp_r <= sat_add(motor, drag_term);
      S_F2:  tmp_r <= sat_add(tmp_r, resist_cur);
      S_TWZ: twx_r <= mres;
      S_TWC: twz_r <= mres;
      default: ;
    endcase
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_vel_r[i] <= to_out(speed_r[i]);
        out_pos_r[i] <= to_out(place_r[i]);
      end
      out_twx_r <= to_out(twx_r);
      out_twz_r <= to_out(twz_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_velocity_x = out_vel_r[0];
  assign out_velocity_y = out_vel_r[1];
  assign out_velocity_z = out_vel_r[2];
  assign out_position_x = out_pos_r[0];
  assign out_position_y = out_pos_r[1];
  assign out_position_z = out_pos_r[2];
  assign out_twist_x    = out_twx_r;
  assign out_twist_z    = out_twz_r;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for point_mass_drag_integrator_top. Every accepted input transfer
// is run through a local fixed-point model of the Euler tick, and the model's
// velocity, position and twist words are queued. Each output transfer is then
// checked field by field against the oldest queued entry.
module tb_top;
  import pmdi_pkg::*;

  // Reset values of the register file, mirrored in the local model.
  localparam longint THRUST_RST = 65536;
  localparam longint INV_MASS_RST = 65536;
  localparam longint STEP_RST = 1092;
  localparam longint IDLE_DRAG_RST = 327680;
  // Index 7 has no register behind it, so a write there must change nothing.
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int TICKS_PER_PHASE = 171;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic signed [1:0] x;
    logic signed [1:0] y;
    logic signed [1:0] z;
  } push_t;

  typedef struct packed {
    logic [OUT_W-1:0] vel_x;
    logic [OUT_W-1:0] vel_y;
    logic [OUT_W-1:0] vel_z;
    logic [OUT_W-1:0] pos_x;
    logic [OUT_W-1:0] pos_y;
    logic [OUT_W-1:0] pos_z;
    logic [OUT_W-1:0] twist_x;
    logic [OUT_W-1:0] twist_z;
  } tick_result_t;

  // All inputs of the block start from known values at time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [1:0] in_push_x = 2'sd0;
  logic signed [1:0] in_push_y = 2'sd0;
  logic signed [1:0] in_push_z = 2'sd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_velocity_x, out_velocity_y, out_velocity_z;
  logic signed [OUT_W-1:0] out_position_x, out_position_y, out_position_z;
  logic signed [OUT_W-1:0] out_twist_x, out_twist_z;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  point_mass_drag_integrator_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_push_x      (in_push_x),
    .in_push_y      (in_push_y),
    .in_push_z      (in_push_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_velocity_x (out_velocity_x),
    .out_velocity_y (out_velocity_y),
    .out_velocity_z (out_velocity_z),
    .out_position_x (out_position_x),
    .out_position_y (out_position_y),
    .out_position_z (out_position_z),
    .out_twist_x    (out_twist_x),
    .out_twist_z    (out_twist_z),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ticks waiting to be offered, and the results the model predicts for the
  // ticks the block has already taken, oldest first.
  push_t tick_q[$];
  tick_result_t result_q[$];

  // Stimulus controls. The calm and long_hold_req flags change only at falling
  // edges, so the clocked driver and monitor always see settled values.
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_left = 0;

  int mismatches = 0;
  int results_seen = 0;
  int ticks_taken = 0;
  int coast_ticks = 0;
  int minus_two_ticks = 0;
  int rail_ticks = 0;
  int settings_run = 0;

  // Local copy of the register file and of the vehicle state.
  longint thrust_r, inv_mass_r, step_r, idle_drag_r;
  longint resist_r[3];
  longint speed[3];
  longint place[3];
  longint drag_cur;
  bit drove;

  function automatic longint clamp_word(longint x);
    if (x > WMAX_L) return WMAX_L;
    if (x < WMIN_L) return WMIN_L;
    return x;
  endfunction

  // Fixed-point product: magnitudes multiplied exactly, fraction bits dropped
  // (so the result truncates toward zero), sign put back, then saturated.
  function automatic longint qmul(longint a, longint b);
    logic [127:0] ua, ub, q, lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    q = (ua * ub) >> FRAC_BITS;
    lim = neg ? 128'(WMAX_L) + 128'd1 : 128'(WMAX_L);
    if (q > lim) return neg ? WMIN_L : WMAX_L;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Any push field with its sign bit set counts as a backward drive, which
  // includes the otherwise unused minus-two pattern.
  function automatic int push_dir(logic signed [1:0] p);
    if (p[1]) return -1;
    return int'(p[0]);
  endfunction

  // One Euler tick of the model for an accepted transfer.
  function automatic tick_result_t advance_tick(push_t p);
    int dir[3];
    int a;
    longint v, motor, d, f;
    tick_result_t r;
    dir[0] = push_dir(p.x);
    dir[1] = push_dir(p.y);
    dir[2] = push_dir(p.z);
    if (p.x == -2'sd2 || p.y == -2'sd2 || p.z == -2'sd2) minus_two_ticks++;
    if (dir[0] == 0 && dir[1] == 0 && dir[2] == 0) begin
      // Coasting: slow components snap to rest.
      coast_ticks++;
      for (a = 0; a < 3; a++) begin
        if (((speed[a] < 0) ? -speed[a] : speed[a]) < SNAP_L) speed[a] = 0;
      end
    end else begin
      // The first driven tick switches to the fixed driving drag for good.
      drag_cur = clamp_word(DRIVE_L);
      drove = 1'b1;
    end
    for (a = 0; a < 3; a++) begin
      v = speed[a];
      motor = 0;
      if (dir[a] > 0) motor = clamp_word(thrust_r);
      else if (dir[a] < 0) motor = -clamp_word(thrust_r);
      // Drag is quadratic in speed and always opposes the motion.
      d = qmul(drag_cur, qmul(v, v));
      f = clamp_word(clamp_word(motor + ((v > 0) ? -d : d)) + clamp_word(resist_r[a]));
      v = clamp_word(v + qmul(qmul(f, clamp_word(inv_mass_r)), clamp_word(step_r)));
      speed[a] = v;
      place[a] = clamp_word(place[a] + qmul(v, clamp_word(step_r)));
      if (v == WMAX_L || v == WMIN_L) rail_ticks++;
    end
    r.vel_x = OUT_W'(speed[0]);
    r.vel_y = OUT_W'(speed[1]);
    r.vel_z = OUT_W'(speed[2]);
    r.pos_x = OUT_W'(place[0]);
    r.pos_y = OUT_W'(place[1]);
    r.pos_z = OUT_W'(place[2]);
    r.twist_x = OUT_W'(qmul(-K03_L, speed[0]));
    r.twist_z = OUT_W'(qmul(K03_L, speed[2]));
    return r;
  endfunction

  function automatic void check_field(string name, logic [OUT_W-1:0] want,
                                      logic [OUT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d (0x%h), actual %0d (0x%h)",
               $time, name, $signed(want), want, $signed(got), got);
    end
  endfunction

  // Driver: offers the next pending tick, holding it until the block takes
  // it. The model advances exactly when a transfer happens, so its state
  // follows the block's own order of ticks.
  always @(posedge clk) begin
    push_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        nxt.x = in_push_x;
        nxt.y = in_push_y;
        nxt.z = in_push_z;
        result_q.push_back(advance_tick(nxt));
        ticks_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          nxt = tick_q.pop_front();
          in_push_x <= nxt.x;
          in_push_y <= nxt.y;
          in_push_z <= nxt.z;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every output transfer and decides the ready for the next
  // cycle. A requested long hold is counted down here, while the driver keeps
  // offering ticks, so the block fills both its work slot and its output
  // register and then has to stall its input.
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          mismatches++;
          $display("%0t: output transfer with no expected result, vel_x actual %0d",
                   $time, out_velocity_x);
        end else begin
          want = result_q.pop_front();
          check_field("velocity_x", want.vel_x, out_velocity_x);
          check_field("velocity_y", want.vel_y, out_velocity_y);
          check_field("velocity_z", want.vel_z, out_velocity_z);
          check_field("position_x", want.pos_x, out_position_x);
          check_field("position_y", want.pos_y, out_position_y);
          check_field("position_z", want.pos_z, out_position_z);
          check_field("twist_x", want.twist_x, out_twist_x);
          check_field("twist_z", want.twist_z, out_twist_z);
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  // Register write: one cycle of write enable, mirrored in the model at once.
  // Only called while no tick is in flight.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_THRUST:    thrust_r = longint'(val[30:0]);
      REG_INV_MASS:  inv_mass_r = longint'(val[30:0]);
      REG_TIME_STEP: step_r = longint'(val[16:0]);
      REG_RESIST_X:  resist_r[0] = longint'($signed(val));
      REG_RESIST_Y:  resist_r[1] = longint'($signed(val));
      REG_RESIST_Z:  resist_r[2] = longint'($signed(val));
      REG_IDLE_DRAG: begin
        // Before the first drive the new coefficient applies right away;
        // after it, only the register changes.
        idle_drag_r = longint'(val[22:0]);
        if (!drove) drag_cur = clamp_word(idle_drag_r);
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Returns at a falling edge once every queued tick has been taken and every
  // expected result has come back, so the block is idle.
  task automatic wait_drained();
    @(negedge clk);
    while (tick_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
    settings_run++;
  endtask

  function automatic push_t tick_of(int x, int y, int z);
    push_t t;
    t.x = 2'(x);
    t.y = 2'(y);
    t.z = 2'(z);
    return t;
  endfunction

  function automatic logic signed [1:0] random_push();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return -2'sd2;
    if (r < 36) return -2'sd1;
    if (r < 68) return 2'sd0;
    return 2'sd1;
  endfunction

  // Random ticks come in runs of one repeated pattern, so velocity builds up
  // under a steady drive and then decays or snaps during coasting runs.
  task automatic queue_random_ticks(int count);
    push_t t;
    int run;
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 30) begin
        t = tick_of(0, 0, 0);
      end else begin
        t.x = random_push();
        t.y = random_push();
        t.z = random_push();
      end
      run = $urandom_range(1, 10);
      while (run > 0 && made < count) begin
        tick_q.push_back(t);
        run--;
        made++;
      end
    end
  endtask

  // Moderate settings: thrust up to 10, mass between 1/4 and 16, short steps
  // and side forces within +-4.
  task automatic write_moderate_regs();
    write_reg(REG_THRUST, $urandom_range(0, 655360));
    write_reg(REG_INV_MASS, $urandom_range(4096, 262144));
    write_reg(REG_TIME_STEP, $urandom_range(1, 8192));
    write_reg(REG_RESIST_X, 32'(int'($urandom_range(0, 524288)) - 262144));
    write_reg(REG_RESIST_Y, 32'(int'($urandom_range(0, 524288)) - 262144));
    write_reg(REG_RESIST_Z, 32'(int'($urandom_range(0, 524288)) - 262144));
    write_reg(REG_IDLE_DRAG, $urandom_range(0, 6553600));
  endtask

  initial begin
    int i;
    thrust_r = THRUST_RST;
    inv_mass_r = INV_MASS_RST;
    step_r = STEP_RST;
    idle_drag_r = IDLE_DRAG_RST;
    for (i = 0; i < 3; i++) begin
      resist_r[i] = 0;
      speed[i] = 0;
      place[i] = 0;
    end
    drag_cur = clamp_word(IDLE_DRAG_RST);
    drove = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any drive: constant side forces push the mass while it coasts,
    // so the idle drag coefficient and the snap threshold act on real speed.
    // The idle drag write also lands in the live coefficient here.
    write_reg(REG_RESIST_X, 32'd196608);
    write_reg(REG_RESIST_Y, -32'sd131072);
    write_reg(REG_RESIST_Z, 32'd32768);
    write_reg(REG_IDLE_DRAG, 32'd65536);
    for (i = 0; i < 8; i++) tick_q.push_back(tick_of(0, 0, 0));
    wait_drained();

    // Directed drives on the reset thrust: each axis alone in one sense, the
    // minus-two pattern, a sustained all-axis drive, and coasting after
    // short drives so small speeds snap to rest.
    write_reg(REG_RESIST_X, 32'd0);
    write_reg(REG_RESIST_Y, 32'd0);
    write_reg(REG_RESIST_Z, 32'd0);
    write_reg(REG_IDLE_DRAG, 32'(IDLE_DRAG_RST));
    tick_q.push_back(tick_of(1, 0, 0));
    tick_q.push_back(tick_of(0, -1, 0));
    tick_q.push_back(tick_of(0, 0, 1));
    tick_q.push_back(tick_of(-2, 1, -1));
    for (i = 0; i < 4; i++) tick_q.push_back(tick_of(1, 1, 1));
    tick_q.push_back(tick_of(0, 0, 0));
    tick_q.push_back(tick_of(0, 0, 0));
    for (i = 0; i < 3; i++) tick_q.push_back(tick_of(-1, -1, -1));
    tick_q.push_back(tick_of(-2, -2, -2));
    tick_q.push_back(tick_of(0, 0, 0));
    tick_q.push_back(tick_of(0, 0, 0));
    wait_drained();

    // Reset values again, with neither side ever idling.
    calm = 1'b1;
    write_reg(REG_THRUST, 32'(THRUST_RST));
    write_reg(REG_INV_MASS, 32'(INV_MASS_RST));
    write_reg(REG_TIME_STEP, 32'(STEP_RST));
    queue_random_ticks(TICKS_PER_PHASE);
    wait_drained();
    calm = 1'b0;

    // Moderate random settings, with one long receiver hold at the start.
    write_moderate_regs();
    @(negedge clk);
    long_hold_req = 1'b1;
    queue_random_ticks(TICKS_PER_PHASE);
    wait_drained();

    // Upper extremes: everything saturates.
    write_reg(REG_THRUST, 32'h7FFF_FFFF);
    write_reg(REG_INV_MASS, 32'h7FFF_FFFF);
    write_reg(REG_TIME_STEP, 32'd65536);
    write_reg(REG_RESIST_X, 32'h7FFF_FFFF);
    write_reg(REG_RESIST_Y, 32'h8000_0000);
    write_reg(REG_RESIST_Z, 32'd0);
    write_reg(REG_IDLE_DRAG, 32'd6553600);
    queue_random_ticks(TICKS_PER_PHASE);
    wait_drained();

    // Lower extremes: no thrust, lightest possible acceleration, zero step.
    write_reg(REG_THRUST, 32'd0);
    write_reg(REG_INV_MASS, 32'd1);
    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(REG_RESIST_X, $urandom);
    write_reg(REG_RESIST_Y, $urandom);
    write_reg(REG_RESIST_Z, $urandom);
    write_reg(REG_IDLE_DRAG, 32'd0);
    queue_random_ticks(TICKS_PER_PHASE);
    wait_drained();

    // Full-range random settings, plus a write to the unused index.
    write_reg(REG_THRUST, $urandom & 32'h7FFF_FFFF);
    write_reg(REG_INV_MASS, $urandom_range(1, 32'h7FFF_FFFF));
    write_reg(REG_TIME_STEP, $urandom_range(0, 65536));
    write_reg(REG_RESIST_X, $urandom);
    write_reg(REG_RESIST_Y, $urandom);
    write_reg(REG_RESIST_Z, $urandom);
    write_reg(REG_IDLE_DRAG, $urandom_range(0, 6553600));
    write_reg(REG_SPARE, $urandom);
    queue_random_ticks(TICKS_PER_PHASE);
    wait_drained();

    // Back to moderate settings to pull the state off the rails.
    write_moderate_regs();
    queue_random_ticks(TICKS_PER_PHASE);
    wait_drained();

    // Anything arriving now is a result nobody asked for.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (result_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, result_q.size());
    end
    $display("Ran %0d ticks over %0d register settings: %0d coasting, %0d with the minus-two push,",
             ticks_taken, settings_run, coast_ticks, minus_two_ticks);
    $display("%0d axis updates ending on a saturation rail; %0d results checked.",
             rail_ticks, results_seen);
    if (mismatches == 0) begin
      $display("** point_mass_drag_integrator_top: PASSED **");
    end else begin
      $display("** point_mass_drag_integrator_top: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #8ms;
    $display("%0t: timeout, %0d ticks pending, %0d results outstanding",
             $time, tick_q.size(), result_q.size());
    $display("** point_mass_drag_integrator_top: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pmdi_pkg.sv
rtl/pmdi_fmul.sv
rtl/pmdi_cfg.sv
rtl/point_mass_drag_integrator_top.sv
dv/tb_top.sv
